// ===== rtl/glacc_pkg.sv =====
`timescale 1ns / 1ps
// types, codes and constants for the gaussian likelihood accumulator
// no dependencies

package glacc_pkg;

  typedef struct packed {
    logic signed [31:0] prediction;
    logic signed [31:0] observed;
    logic [31:0]        sigma;
    logic               is_last;
  } in_t;

  typedef struct packed {
    logic signed [33:0] residual;
    logic signed [47:0] weight;
    logic [47:0]        likelihood_sum;
    logic signed [47:0] norm_sum;
    logic               last;
    logic               bad_scale;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_N,
    ST_CHECK,
    ST_MUL_HL,
    ST_MUL_HH,
    ST_MUL_SQ,
    ST_NORM,
    ST_MUL_LN,
    ST_DIV_W,
    ST_DIV_L,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_N,
    MUL_LL,
    MUL_HL,
    MUL_HH,
    MUL_SQ,
    MUL_LN
  } mul_op_t;

  typedef struct packed {
    logic    cap;
    mul_op_t mul_op;
    logic    norm_load;
    logic    norm_en;
    logic [2:0] norm_stage;
    logic    div_load_w;
    logic    div_load_l;
    logic    div_step;
    logic    div_store_w;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic bad;
  } status_t;

  localparam int DIV_STEPS  = 48;
  localparam int NORM_STEPS = 6;
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  localparam logic [15:0] HALF_LN_2PI_Q16 = 16'd60224;
  localparam logic [2:0]  CFG_IDX_NOISE = 3'd0;

  // fraction of log2(1 + i/2^tb) in q.16, by repeated squaring in q1.30
  function automatic logic [15:0] log2_frac(input int tb, input int i);
    logic [63:0] x;
    logic [15:0] f;
    x = 64'((64'(1) << tb) + 64'(i)) << (30 - tb);
    f = '0;
    for (int s = 0; s < 16; s++) begin
      x = (x * x) >> 30;
      f = {f[14:0], 1'b0};
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        f[0] = 1'b1;
      end
    end
    return f;
  endfunction

endpackage

// ===== rtl/gaussian_likelihood_accumulator.sv =====
`timescale 1ns / 1ps
// top level: config register, controller and datapath of the likelihood accumulator
// depends on glacc_pkg, glacc_ctrl, glacc_dp
//
//   channel  signals                          direction
//   in       in_valid, in_stall, in_data      observation beats in
//   out      out_valid, out_stall, out_data   one result beat per observation
//   cfg      cfg_p* (apb style)               noise_scale at byte address 0
//
// from acceptance to a loaded result an observation runs six steps on one shared 33x33
// multiplier, a six step normalizer and two 48 step passes of one restoring divider;
// with zero scale it goes from the check straight to the output state
// a new beat is accepted once the previous one is loaded into the output register
// rst_n is synchronous; it clears the sums, the control state and sets noise_scale to 1.0

module gaussian_likelihood_accumulator import glacc_pkg::*; #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [23:0] noise_r;
  cmd_t        cmd;
  status_t     stat;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_IDX_NOISE) ? 32'(noise_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r <= 24'd65536;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == CFG_IDX_NOISE) begin
      noise_r <= cfg_pwdata[23:0];
    end
  end

  glacc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  glacc_dp #(
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .noise_scale (noise_r),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/glacc_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing state machine for the likelihood accumulator
// depends on glacc_pkg

module glacc_ctrl import glacc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL_N;
      ST_MUL_N:  state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = stat.bad ? ST_OUT : ST_MUL_HL;
      ST_MUL_HL: state_nxt = ST_MUL_HH;
      ST_MUL_HH: state_nxt = ST_MUL_SQ;
      ST_MUL_SQ: begin
        state_nxt = ST_NORM;
        cnt_nxt   = '0;
      end
      ST_NORM: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(NORM_STEPS - 1)) state_nxt = ST_MUL_LN;
      end
      ST_MUL_LN: begin
        state_nxt = ST_DIV_W;
        cnt_nxt   = '0;
      end
      ST_DIV_W: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS)) begin
          state_nxt = ST_DIV_L;
          cnt_nxt   = '0;
        end
      end
      ST_DIV_L: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS)) state_nxt = ST_OUT;
      end
      ST_OUT:    if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // each divide pass loads while its counter is zero and iterates while the counter runs up to DIV_STEPS
  always_comb begin
    cmd = '0;
    cmd.mul_op = MUL_NONE;
    case (state_r)
      ST_IDLE:   cmd.cap = in_valid;
      ST_MUL_N:  cmd.mul_op = MUL_N;
      ST_CHECK: begin
        cmd.mul_op    = MUL_LL;
        cmd.norm_load = 1'b1;
      end
      ST_MUL_HL: cmd.mul_op = MUL_HL;
      ST_MUL_HH: cmd.mul_op = MUL_HH;
      ST_MUL_SQ: cmd.mul_op = MUL_SQ;
      ST_NORM: begin
        cmd.norm_en    = 1'b1;
        cmd.norm_stage = cnt_r[2:0];
      end
      ST_MUL_LN: cmd.mul_op = MUL_LN;
      ST_DIV_W: begin
        cmd.div_load_w = (cnt_r == 6'd0);
        cmd.div_step   = (cnt_r != 6'd0);
      end
      ST_DIV_L: begin
        cmd.div_store_w = (cnt_r == 6'd0);
        cmd.div_load_l  = (cnt_r == 6'd0);
        cmd.div_step    = (cnt_r != 6'd0);
      end
      ST_OUT:    cmd.out_load = slot_free;
      default:   cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over an untaken beat");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_MUL_N))
    else $error("accepted beat did not start the sequence");

  a_div_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_W && cnt_r == 6'(DIV_STEPS)) |=> (state_r == ST_DIV_L))
    else $error("second divide pass did not follow the first");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !slot_free) |=> (state_r == ST_OUT))
    else $error("left output state while slot busy");

endmodule

// ===== rtl/glacc_dp.sv =====
`timescale 1ns / 1ps
// datapath: shared multiplier, normalizer, restoring divider, accumulators
// depends on glacc_pkg

module glacc_dp import glacc_pkg::*; #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [23:0] noise_scale,
  input  in_t         in_data,
  input  cmd_t        cmd,
  output status_t     stat,
  output out_t        out_data
);

  localparam int TAB_SIZE = 1 << LOG_TABLE_BITS;

  logic signed [33:0] res_r;
  logic [32:0]  mag_r;
  logic [31:0]  sigma_r;
  logic         last_r;
  logic [55:0]  n_r;
  logic [111:0] nsq_r;
  logic [64:0]  sq_r;
  logic [53:0]  lnp_r;
  logic         l2neg_r;
  logic [55:0]  nrm_r;
  logic [5:0]   sh_r;
  logic [111:0] rem_r;
  logic         nb_r;
  logic [47:0]  q_r;
  logic         ovf_r;
  logic signed [47:0] w_r;
  logic [47:0]  lacc_r;
  logic signed [47:0] nacc_r;
  out_t         out_r;

  logic [15:0]  tab [TAB_SIZE];
  logic [32:0]  mul_a, mul_b;
  logic [65:0]  prod;
  logic signed [32:0] diff;
  logic signed [6:0]  kk;
  logic signed [22:0] l2;
  logic [22:0]  l2mag;
  logic [112:0] trial;
  logic         ge;
  logic [54:0]  lnr;
  logic [22:0]  rnd;
  logic signed [24:0] nterm;
  logic [47:0]  wmag, lterm;
  logic [48:0]  lsum;
  logic signed [48:0] nsum;
  logic [47:0]  lacc_new;
  logic signed [47:0] nacc_new;

  for (genvar g = 0; g < TAB_SIZE; g++) begin : g_tab
    assign tab[g] = log2_frac(LOG_TABLE_BITS, g);
  end

  assign diff  = 33'(in_data.prediction) - 33'(in_data.observed);
  assign stat.bad = (n_r == '0);

  // log2(n) - 32 in q.16: integer part and table fraction concatenate
  assign kk    = 7'sd23 - $signed({1'b0, sh_r});
  assign l2    = $signed({kk, tab[nrm_r[54 -: LOG_TABLE_BITS]]});
  assign l2mag = l2[22] ? 23'(-l2) : 23'(l2);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_N: begin
        mul_a = 33'(noise_scale);
        mul_b = 33'(sigma_r);
      end
      MUL_LL: begin
        mul_a = 33'(n_r[27:0]);
        mul_b = 33'(n_r[27:0]);
      end
      MUL_HL: begin
        mul_a = 33'(n_r[55:28]);
        mul_b = 33'(n_r[27:0]);
      end
      MUL_HH: begin
        mul_a = 33'(n_r[55:28]);
        mul_b = 33'(n_r[55:28]);
      end
      MUL_SQ: begin
        mul_a = mag_r;
        mul_b = mag_r;
      end
      MUL_LN: begin
        mul_a = 33'(l2mag);
        mul_b = 33'(LN2_Q32);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign trial = {rem_r, nb_r};
  assign ge    = trial >= {1'b0, nsq_r};

  assign lnr   = 55'(lnp_r) + 55'h80000000;
  assign rnd   = lnr[54:32];
  assign nterm = l2neg_r ? 25'(HALF_LN_2PI_Q16) - 25'(rnd)
                         : 25'(HALF_LN_2PI_Q16) + 25'(rnd);

  always_comb begin
    if (res_r[33]) wmag = (ovf_r || q_r > 48'h800000000000) ? 48'h800000000000 : q_r;
    else           wmag = (ovf_r || q_r > 48'h7FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF : q_r;
  end

  assign lterm = ovf_r ? '1 : q_r;
  assign lsum  = 49'(lacc_r) + 49'(lterm);
  assign nsum  = 49'(nacc_r) + 49'(nterm);

  always_comb begin
    lacc_new = lsum[48] ? '1 : lsum[47:0];
    if (nsum > 49'sh7FFFFFFFFFFF)       nacc_new = 48'sh7FFFFFFFFFFF;
    else if (nsum < -49'sh800000000000) nacc_new = 48'sh800000000000;
    else                                nacc_new = nsum[47:0];
    if (stat.bad) begin
      lacc_new = lacc_r;
      nacc_new = nacc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      res_r   <= 34'(diff);
      mag_r   <= diff[32] ? 33'(-diff) : 33'(diff);
      sigma_r <= in_data.sigma;
      last_r  <= in_data.is_last;
    end
    case (cmd.mul_op)
      MUL_N:   n_r   <= prod[55:0];
      MUL_LL:  nsq_r <= 112'(prod[55:0]);
      MUL_HL:  nsq_r <= nsq_r + {27'b0, prod[55:0], 29'b0};
      MUL_HH:  nsq_r <= nsq_r + {prod[55:0], 56'b0};
      MUL_SQ:  sq_r  <= prod[64:0];
      MUL_LN: begin
        lnp_r   <= prod[53:0];
        l2neg_r <= l2[22];
      end
      default: ;
    endcase
    if (cmd.norm_load) begin
      nrm_r <= n_r;
      sh_r  <= '0;
    end else if (cmd.norm_en) begin
      case (cmd.norm_stage)
        3'd0: if (nrm_r[55:24] == '0) begin nrm_r <= nrm_r << 32; sh_r <= sh_r + 6'd32; end
        3'd1: if (nrm_r[55:40] == '0) begin nrm_r <= nrm_r << 16; sh_r <= sh_r + 6'd16; end
        3'd2: if (nrm_r[55:48] == '0) begin nrm_r <= nrm_r << 8;  sh_r <= sh_r + 6'd8;  end
        3'd3: if (nrm_r[55:52] == '0) begin nrm_r <= nrm_r << 4;  sh_r <= sh_r + 6'd4;  end
        3'd4: if (nrm_r[55:54] == '0) begin nrm_r <= nrm_r << 2;  sh_r <= sh_r + 6'd2;  end
        3'd5: if (!nrm_r[55])         begin nrm_r <= nrm_r << 1;  sh_r <= sh_r + 6'd1;  end
        default: ;
      endcase
    end
    if (cmd.div_store_w) w_r <= res_r[33] ? -$signed(wmag) : $signed(wmag);
    if (cmd.div_load_w) begin
      rem_r <= 112'({mag_r, 16'b0});
      nb_r  <= 1'b0;
      ovf_r <= 112'({mag_r, 16'b0}) >= nsq_r;
    end else if (cmd.div_load_l) begin
      rem_r <= 112'(sq_r[64:1]);
      nb_r  <= sq_r[0];
      ovf_r <= 112'(sq_r[64:1]) >= nsq_r;
    end else if (cmd.div_step) begin
      rem_r <= ge ? 112'(trial - {1'b0, nsq_r}) : trial[111:0];
      nb_r  <= 1'b0;
      q_r   <= {q_r[46:0], ge};
    end
    if (cmd.out_load) begin
      out_r.residual       <= res_r;
      out_r.weight         <= stat.bad ? '0 : w_r;
      out_r.likelihood_sum <= last_r ? lacc_new : '0;
      out_r.norm_sum       <= last_r ? nacc_new : '0;
      out_r.last           <= last_r;
      out_r.bad_scale      <= stat.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lacc_r <= '0;
      nacc_r <= '0;
    end else if (cmd.out_load) begin
      lacc_r <= last_r ? '0 : lacc_new;
      nacc_r <= last_r ? '0 : nacc_new;
    end
  end

  assign out_data = out_r;

endmodule
